// ----- hw/rtl/gcd_pkg.sv -----
// Shared constants and elaboration-time helpers for the great circle distance block.
// Holds the fixed-point angle constants and the CORDIC table builders.
// No dependencies.
`timescale 1ns / 1ps

package gcd_pkg;

    typedef logic [63:0] u64_t;

    // pi in Q60 and the number of 1e-7 degree units in half a turn
    localparam u64_t PI_Q60           = 64'h3243F6A8885A308D;
    localparam u64_t E7_PER_HALF_TURN = 64'd1800000000;

    // Degree (1e-7) to radian factor in Q59, rounded to nearest.
    localparam u64_t DEG_K_FULL = ((PI_Q60 >> 1) + (E7_PER_HALF_TURN >> 1)) / E7_PER_HALF_TURN;
    localparam int   DEG_K_W    = 30;
    localparam logic [DEG_K_W-1:0] DEG_K = DEG_K_FULL[DEG_K_W-1:0];

    localparam int DEG_W      = 33;
    localparam int LANES      = 4;
    localparam int RADIUS_W   = 23;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;
    localparam int RAD_CM_W   = 30;
    localparam logic [6:0] CM_PER_M = 7'd100;
    localparam int MUL_LAT    = 4;
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_W     = 32;
    localparam int VEC_W      = 34;
    localparam int DIST_W     = 32;
    localparam int DIST_OW    = 34;

    // Restoring division, used only while the tables are built.
    function automatic u64_t udiv64(input u64_t num, input u64_t den);
        u64_t q;
        u64_t rem;
        q   = '0;
        rem = '0;
        for (int k = 63; k >= 0; k--)
        begin
            rem = {rem[62:0], num[k]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic u64_t rnd_u(input u64_t v, input int s);
        return (v + (u64_t'(1) << (s - 1))) >> s;
    endfunction

    function automatic u64_t pi_q(input int f);
        return rnd_u(PI_Q60, 60 - f);
    endfunction

    // atan(2^-i) in Q.f, from an alternating power series in Q62.
    function automatic u64_t atan_q(input int i, input int f);
        u64_t sum;
        u64_t term;
        int   e;
        if (i == 0)
            return rnd_u(PI_Q60, 62 - f);
        sum = '0;
        for (int k = 0; k < 32; k++)
        begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0)
            begin
                term = udiv64(u64_t'(1) << e, u64_t'(2 * k + 1));
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return rnd_u(sum, 62 - f);
    endfunction

    // Square of the reciprocal CORDIC gain in Q.f.
    function automatic u64_t inv_gain_sq(input int n, input int f);
        u64_t g;
        g = u64_t'(1) << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (i < n)
                g = g - udiv64(g, (u64_t'(1) << (2 * i)) + u64_t'(1));
        end
        return rnd_u(g, 62 - f);
    endfunction

endpackage

// ----- hw/rtl/gcd_mul.sv -----
// Pipelined signed multiplier with rounding shift (half away from zero).
// Splits the magnitudes into halves so that no single product is wide.
// No package dependencies.
`timescale 1ns / 1ps

module gcd_mul #(
    parameter int W  = 34,
    parameter int S  = 30,
    parameter int OW = 34
) (
    input  logic                 clk,
    input  logic signed [W-1:0]  a,
    input  logic signed [W-1:0]  b,
    output logic signed [OW-1:0] p
);

    localparam int LW = (W + 1) / 2;
    localparam int HW = W - LW;
    localparam int SW = 2 * W + 1;
    localparam logic [SW-1:0] RND = SW'(1) << (S - 1);

    logic [2:0]        neg_reg;
    logic [W-1:0]      ma_reg;
    logic [W-1:0]      mb_reg;
    logic [2*LW-1:0]   ll_reg;
    logic [W-1:0]      lh_reg;
    logic [W-1:0]      hl_reg;
    logic [2*HW-1:0]   hh_reg;
    logic [SW-1:0]     sum_reg;
    logic signed [OW-1:0] p_reg;
    logic [SW-1:0]     shifted;
    logic [OW-1:0]     mag;
    logic signed [OW-1:0] p_next;

    always_ff @(posedge clk)
    begin
        neg_reg <= {neg_reg[1:0], a[W-1] ^ b[W-1]};
        ma_reg  <= a[W-1] ? W'(-a) : W'(a);
        mb_reg  <= b[W-1] ? W'(-b) : W'(b);
        ll_reg  <= ma_reg[LW-1:0] * mb_reg[LW-1:0];
        lh_reg  <= ma_reg[LW-1:0] * mb_reg[W-1:LW];
        hl_reg  <= ma_reg[W-1:LW] * mb_reg[LW-1:0];
        hh_reg  <= ma_reg[W-1:LW] * mb_reg[W-1:LW];
        sum_reg <= SW'(ll_reg) + (SW'(lh_reg) << LW) + (SW'(hl_reg) << LW)
                   + (SW'(hh_reg) << (2 * LW)) + RND;
        p_reg   <= p_next;
    end

    always_comb
    begin
        shifted = sum_reg >> S;
        mag     = shifted[OW-1:0];
        p_next  = neg_reg[2] ? -signed'(mag) : signed'(mag);
    end

    assign p = p_reg;

endmodule

// ----- hw/rtl/great_circle_distance_top.sv -----
// Top level of the great circle distance block: haversine datapath in a deep pipeline.
// Depends on gcd_pkg (constants, table builders) and gcd_mul (pipelined multiplier).
// Holds the sphere radius register and all CORDIC and square root stages.
`timescale 1ns / 1ps

// How to use this block
// ---------------------
// A beat on the input side is one pair of fixes: first_latitude, first_longitude,
// second_latitude and second_longitude, in units of 1e-7 degree. The beat is taken at
// a rising edge where start is high and busy is low. busy stays low at all times,
// because every stage of the datapath advances on every clock, so one beat may be
// offered in every cycle.
// The result beat, distance_cm, is presented for exactly one cycle with done high. On
// its way the beat passes the seven-stage front end, the two CORDIC pipelines (one
// stage per iteration), the 32-step square root pipeline, five four-stage multipliers
// in series and the single registers between them.
// Throughput is one beat per cycle. The receiver cannot stall the block, and there is
// nothing to hold off: results leave in the order their beats arrived.
// The sphere radius in metres is written through cfg_wr_en and cfg_wr_data; change it
// only while no beat is in flight. Reset clears every valid bit, drops done and loads
// the radius register with 6371000 m. Items in flight at reset are discarded.

module great_circle_distance_top
    import gcd_pkg::*;
#(
    parameter int CORDIC_STAGES       = 24,
    parameter int ANGLE_FRACTION_BITS = 30
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [30:0]    first_latitude,
    input  logic signed [31:0]    first_longitude,
    input  logic signed [30:0]    second_latitude,
    input  logic signed [31:0]    second_longitude,
    input  logic                  cfg_wr_en,
    input  logic [RADIUS_W-1:0]   cfg_wr_data,
    output logic                  done,
    output logic [DIST_W-1:0]     distance_cm
);

    localparam int F   = ANGLE_FRACTION_BITS;
    localparam int N   = CORDIC_STAGES;
    // Q.F values carry three integer bits and a sign, which covers every
    // intermediate of the haversine sum.
    localparam int QW  = F + 4;
    localparam int PW  = DEG_W + DEG_K_W;
    localparam int SH0 = 59 - F;
    localparam int SQ_SH = 62 - F;
    localparam int MW  = (QW + 1 > RAD_CM_W + 1) ? QW + 1 : RAD_CM_W + 1;
    localparam int LAT = 2 * N + 65;

    localparam u64_t PI_U      = pi_q(F);
    localparam u64_t TWO_PI_U  = PI_U << 1;
    localparam u64_t HALF_PI_U = PI_U >> 1;
    localparam u64_t ONE_U     = u64_t'(1) << F;
    localparam u64_t G_U       = inv_gain_sq(N, F);
    localparam u64_t RND0      = u64_t'(1) << (SH0 - 1);
    localparam u64_t RND1      = u64_t'(1) << SH0;

    localparam logic signed [QW-1:0] PI_Q      = PI_U[QW-1:0];
    localparam logic signed [QW-1:0] TWO_PI_Q  = TWO_PI_U[QW-1:0];
    localparam logic signed [QW-1:0] HALF_PI_Q = HALF_PI_U[QW-1:0];
    localparam logic signed [QW-1:0] ONE_Q     = ONE_U[QW-1:0];
    localparam logic signed [QW-1:0] G_Q       = G_U[QW-1:0];
    localparam logic [F:0]           ONE_F     = ONE_U[F:0];

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Radius register and its centimetre scaling
    logic [RADIUS_W-1:0] radius_reg;
    logic [RAD_CM_W-1:0] rad100_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_wr_en)
            radius_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk)
    begin
        rad100_reg <= RAD_CM_W'(radius_reg) * RAD_CM_W'(CM_PER_M);
    end

    // Front end: degrees to radians, range reduction and quadrant fold.
    // Lane 0 is the first latitude, lane 1 the second, lane 2 the half latitude
    // difference and lane 3 the half longitude difference.
    logic [5:0]                  fvld_reg;
    logic signed [DEG_W-1:0]     deg_reg  [LANES];
    logic [DEG_W-1:0]            mag_reg  [LANES];
    logic                        neg_reg  [3][LANES];
    logic [PW-1:0]               prod_reg [LANES];
    logic [63:0]                 rnd_reg  [LANES];
    logic signed [QW-1:0]        rad_reg  [LANES];
    logic signed [QW-1:0]        red_reg  [LANES];
    logic signed [QW-1:0]        rad_next [LANES];
    logic signed [QW-1:0]        red_next [LANES];
    logic [63:0]                 shr_w    [LANES];
    logic [QW-1:0]               radm_w   [LANES];

    // Rotation CORDIC, index 0 holds the folded angle
    logic signed [QW-1:0] rx_reg [0:N][LANES];
    logic signed [QW-1:0] ry_reg [0:N][LANES];
    logic signed [QW-1:0] rt_reg [0:N][LANES];
    logic                 rflip_reg [0:N][LANES];
    logic                 rvld_reg [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvld_reg    <= '0;
            rvld_reg[0] <= 1'b0;
        end
        else
        begin
            fvld_reg    <= {fvld_reg[4:0], accept};
            rvld_reg[0] <= fvld_reg[5];
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            shr_w[l]    = (l < 2) ? (rnd_reg[l] >> SH0) : (rnd_reg[l] >> (SH0 + 1));
            radm_w[l]   = shr_w[l][QW-1:0];
            rad_next[l] = neg_reg[2][l] ? -signed'(radm_w[l]) : signed'(radm_w[l]);
            if (rad_reg[l] > PI_Q)
                red_next[l] = rad_reg[l] - TWO_PI_Q;
            else if (rad_reg[l] < -PI_Q)
                red_next[l] = rad_reg[l] + TWO_PI_Q;
            else
                red_next[l] = rad_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg[0] <= DEG_W'(first_latitude);
        deg_reg[1] <= DEG_W'(second_latitude);
        deg_reg[2] <= DEG_W'(second_latitude) - DEG_W'(first_latitude);
        deg_reg[3] <= DEG_W'(second_longitude) - DEG_W'(first_longitude);
        for (int l = 0; l < LANES; l++)
        begin
            mag_reg[l]    <= deg_reg[l][DEG_W-1] ? DEG_W'(-deg_reg[l]) : DEG_W'(deg_reg[l]);
            neg_reg[0][l] <= deg_reg[l][DEG_W-1];
            neg_reg[1][l] <= neg_reg[0][l];
            neg_reg[2][l] <= neg_reg[1][l];
            prod_reg[l]   <= PW'(mag_reg[l]) * PW'(DEG_K);
            rnd_reg[l]    <= {1'b0, prod_reg[l]} + ((l < 2) ? RND0 : RND1);
            rad_reg[l]    <= rad_next[l];
            red_reg[l]    <= red_next[l];
            rx_reg[0][l]  <= ONE_Q;
            ry_reg[0][l]  <= '0;
            if (red_reg[l] > HALF_PI_Q)
            begin
                rt_reg[0][l]    <= red_reg[l] - PI_Q;
                rflip_reg[0][l] <= 1'b1;
            end
            else if (red_reg[l] < -HALF_PI_Q)
            begin
                rt_reg[0][l]    <= red_reg[l] + PI_Q;
                rflip_reg[0][l] <= 1'b1;
            end
            else
            begin
                rt_reg[0][l]    <= red_reg[l];
                rflip_reg[0][l] <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_rot
        localparam u64_t AT_U = atan_q(g, F);
        localparam logic signed [QW-1:0] AT_Q = AT_U[QW-1:0];
        logic signed [QW-1:0] x_next [LANES];
        logic signed [QW-1:0] y_next [LANES];
        logic signed [QW-1:0] t_next [LANES];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (!rt_reg[g][l][QW-1])
                begin
                    x_next[l] = rx_reg[g][l] - (ry_reg[g][l] >>> g);
                    y_next[l] = ry_reg[g][l] + (rx_reg[g][l] >>> g);
                    t_next[l] = rt_reg[g][l] - AT_Q;
                end
                else
                begin
                    x_next[l] = rx_reg[g][l] + (ry_reg[g][l] >>> g);
                    y_next[l] = ry_reg[g][l] - (rx_reg[g][l] >>> g);
                    t_next[l] = rt_reg[g][l] + AT_Q;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rvld_reg[g+1] <= 1'b0;
            else
                rvld_reg[g+1] <= rvld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rx_reg[g+1][l]    <= x_next[l];
                ry_reg[g+1][l]    <= y_next[l];
                rt_reg[g+1][l]    <= t_next[l];
                rflip_reg[g+1][l] <= rflip_reg[g][l];
            end
        end
    end

    // Pick cosines of the latitudes and sines of the half differences.
    logic signed [QW-1:0] trig_reg [LANES];
    logic signed [QW-1:0] trig_w   [LANES];
    logic                 tvld_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trig_w[l] = (l < 2) ? rx_reg[N][l] : ry_reg[N][l];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trig_reg[l] <= rflip_reg[N][l] ? -trig_w[l] : trig_w[l];
        end
    end

    // Haversine term: g * (sin^2(dlat/2) + (g * cos1 * cos2) * sin^2(dlon/2))
    logic signed [QW-1:0] sq_lat;
    logic signed [QW-1:0] sq_lon;
    logic signed [QW-1:0] c12;
    logic signed [QW-1:0] cc;
    logic signed [QW-1:0] lon_term;
    logic signed [QW-1:0] hav;
    logic signed [QW-1:0] lat_dly_reg [2*MUL_LAT];
    logic signed [QW-1:0] lon_dly_reg [MUL_LAT];
    logic signed [QW-1:0] hsum_reg;
    logic [MUL_LAT-1:0]   m1vld_reg;
    logic [MUL_LAT-1:0]   m4vld_reg;
    logic [MUL_LAT-1:0]   m5vld_reg;
    logic [MUL_LAT-1:0]   m6vld_reg;
    logic                 svld_reg;
    logic                 hvld_reg;
    logic [F:0]           hav_c_reg;

    gcd_mul #(.W(QW), .S(F), .OW(QW)) u_sq_lat (
        .clk (clk),
        .a   (trig_reg[2]),
        .b   (trig_reg[2]),
        .p   (sq_lat)
    );

    gcd_mul #(.W(QW), .S(F), .OW(QW)) u_sq_lon (
        .clk (clk),
        .a   (trig_reg[3]),
        .b   (trig_reg[3]),
        .p   (sq_lon)
    );

    gcd_mul #(.W(QW), .S(F), .OW(QW)) u_cos_prod (
        .clk (clk),
        .a   (trig_reg[0]),
        .b   (trig_reg[1]),
        .p   (c12)
    );

    gcd_mul #(.W(QW), .S(F), .OW(QW)) u_cos_gain (
        .clk (clk),
        .a   (c12),
        .b   (G_Q),
        .p   (cc)
    );

    gcd_mul #(.W(QW), .S(F), .OW(QW)) u_lon_term (
        .clk (clk),
        .a   (cc),
        .b   (lon_dly_reg[MUL_LAT-1]),
        .p   (lon_term)
    );

    gcd_mul #(.W(QW), .S(F), .OW(QW)) u_hav_gain (
        .clk (clk),
        .a   (G_Q),
        .b   (hsum_reg),
        .p   (hav)
    );

    always_ff @(posedge clk)
    begin
        lat_dly_reg[0] <= sq_lat;
        for (int k = 1; k < 2 * MUL_LAT; k++)
        begin
            lat_dly_reg[k] <= lat_dly_reg[k-1];
        end
        lon_dly_reg[0] <= sq_lon;
        for (int k = 1; k < MUL_LAT; k++)
        begin
            lon_dly_reg[k] <= lon_dly_reg[k-1];
        end
        hsum_reg <= lat_dly_reg[2*MUL_LAT-1] + lon_term;
        // The rounding in the products can push the term just outside [0, 1].
        if (hav[QW-1])
            hav_c_reg <= '0;
        else if (hav > ONE_Q)
            hav_c_reg <= ONE_F;
        else
            hav_c_reg <= hav[F:0];
    end

    // Square roots of hav and 1 - hav, two bits per stage.
    // Lane 0 is the root of hav, lane 1 the root of 1 - hav.
    logic [63:0] qv_reg [0:ROOT_STEPS][2];
    logic [63:0] qr_reg [0:ROOT_STEPS][2];
    logic        qvld_reg [0:ROOT_STEPS];

    always_ff @(posedge clk)
    begin
        qv_reg[0][0] <= 64'(hav_c_reg) << SQ_SH;
        qv_reg[0][1] <= 64'(ONE_F - hav_c_reg) << SQ_SH;
        qr_reg[0][0] <= '0;
        qr_reg[0][1] <= '0;
    end

    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        localparam u64_t BIT = u64_t'(1) << (62 - 2 * j);
        logic [63:0] trial [2];
        logic [63:0] v_next [2];
        logic [63:0] r_next [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = qr_reg[j][l] + BIT;
                if (qv_reg[j][l] >= trial[l])
                begin
                    v_next[l] = qv_reg[j][l] - trial[l];
                    r_next[l] = (qr_reg[j][l] >> 1) + BIT;
                end
                else
                begin
                    v_next[l] = qv_reg[j][l];
                    r_next[l] = qr_reg[j][l] >> 1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                qvld_reg[j+1] <= 1'b0;
            else
                qvld_reg[j+1] <= qvld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            for (int l = 0; l < 2; l++)
            begin
                qv_reg[j+1][l] <= v_next[l];
                qr_reg[j+1][l] <= r_next[l];
            end
        end
    end

    // Vectoring CORDIC: the central angle is atan2(sqrt(hav), sqrt(1 - hav)).
    logic signed [VEC_W-1:0] vx_reg [0:N];
    logic signed [VEC_W-1:0] vy_reg [0:N];
    logic signed [QW-1:0]    vz_reg [0:N];
    logic                    vvld_reg [0:N];

    always_ff @(posedge clk)
    begin
        vx_reg[0] <= VEC_W'(qr_reg[ROOT_STEPS][1][ROOT_W-1:0]);
        vy_reg[0] <= VEC_W'(qr_reg[ROOT_STEPS][0][ROOT_W-1:0]);
        vz_reg[0] <= '0;
    end

    for (genvar g = 0; g < N; g++)
    begin : g_vec
        localparam u64_t AT_U = atan_q(g, F);
        localparam logic signed [QW-1:0] AT_Q = AT_U[QW-1:0];
        logic signed [VEC_W-1:0] x_next;
        logic signed [VEC_W-1:0] y_next;
        logic signed [QW-1:0]    z_next;

        always_comb
        begin
            if (!vy_reg[g][VEC_W-1])
            begin
                x_next = vx_reg[g] + (vy_reg[g] >>> g);
                y_next = vy_reg[g] - (vx_reg[g] >>> g);
                z_next = vz_reg[g] + AT_Q;
            end
            else
            begin
                x_next = vx_reg[g] - (vy_reg[g] >>> g);
                y_next = vy_reg[g] + (vx_reg[g] >>> g);
                z_next = vz_reg[g] - AT_Q;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vvld_reg[g+1] <= 1'b0;
            else
                vvld_reg[g+1] <= vvld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            vx_reg[g+1] <= x_next;
            vy_reg[g+1] <= y_next;
            vz_reg[g+1] <= z_next;
        end
    end

    // Distance = 2 * angle * radius_cm, rounded, then limited to the output range.
    logic signed [QW:0]         two_z;
    logic signed [MW-1:0]       dist_a;
    logic signed [MW-1:0]       dist_b;
    logic signed [DIST_OW-1:0]  dist_p;
    logic [MUL_LAT-1:0]         m7vld_reg;
    logic                       done_reg;
    logic [DIST_W-1:0]          distance_cm_reg;

    assign two_z  = {vz_reg[N], 1'b0};
    assign dist_a = MW'(two_z);
    assign dist_b = MW'(rad100_reg);

    gcd_mul #(.W(MW), .S(F), .OW(DIST_OW)) u_dist (
        .clk (clk),
        .a   (dist_a),
        .b   (dist_b),
        .p   (dist_p)
    );

    always_ff @(posedge clk)
    begin
        if (dist_p[DIST_OW-1])
            distance_cm_reg <= '0;
        else if (|dist_p[DIST_OW-2:DIST_W])
            distance_cm_reg <= '1;
        else
            distance_cm_reg <= dist_p[DIST_W-1:0];
    end

    // Valid bits that travel alongside the back half of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvld_reg    <= 1'b0;
            m1vld_reg   <= '0;
            m4vld_reg   <= '0;
            m5vld_reg   <= '0;
            svld_reg    <= 1'b0;
            m6vld_reg   <= '0;
            hvld_reg    <= 1'b0;
            qvld_reg[0] <= 1'b0;
            vvld_reg[0] <= 1'b0;
            m7vld_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            tvld_reg    <= rvld_reg[N];
            m1vld_reg   <= {m1vld_reg[MUL_LAT-2:0], tvld_reg};
            m4vld_reg   <= {m4vld_reg[MUL_LAT-2:0], m1vld_reg[MUL_LAT-1]};
            m5vld_reg   <= {m5vld_reg[MUL_LAT-2:0], m4vld_reg[MUL_LAT-1]};
            svld_reg    <= m5vld_reg[MUL_LAT-1];
            m6vld_reg   <= {m6vld_reg[MUL_LAT-2:0], svld_reg};
            hvld_reg    <= m6vld_reg[MUL_LAT-1];
            qvld_reg[0] <= hvld_reg;
            vvld_reg[0] <= qvld_reg[ROOT_STEPS];
            m7vld_reg   <= {m7vld_reg[MUL_LAT-2:0], vvld_reg[N]};
            done_reg    <= m7vld_reg[MUL_LAT-1];
        end
    end

    assign done        = done_reg;
    assign distance_cm = distance_cm_reg;

    // Every result beat stems from an input beat taken a fixed latency earlier.
    a_fixed_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without a matching input beat");

    // The square roots never exceed one in Q31.
    a_root_range : assert property (@(posedge clk) disable iff (!rst_n)
        qvld_reg[ROOT_STEPS] |->
            (qr_reg[ROOT_STEPS][0] <= (u64_t'(1) << 31)) &&
            (qr_reg[ROOT_STEPS][1] <= (u64_t'(1) << 31)))
        else $error("square root out of range");

    // A zero radius gives a zero distance.
    a_zero_radius : assert property (@(posedge clk) disable iff (!rst_n)
        done && (radius_reg == '0) && $stable(radius_reg) |-> distance_cm == '0)
        else $error("non-zero distance for zero radius");

endmodule
